// File: rtl/fwps_pkg.sv
// ----------------------------------------------------------------------------
// fwps_pkg
// Shared constants, payload types and sequencer states of the flash write
// page splitter.
// ----------------------------------------------------------------------------
package fwps_pkg;

    localparam int PAGE_BYTES        = 256;
    localparam int MAX_REQUEST_BYTES = 4096;

    localparam int ADDR_W  = 24;
    localparam int COUNT_W = 13;
    localparam int LEN_W   = 9;
    localparam int OFF_W   = $clog2(PAGE_BYTES);

    localparam logic [COUNT_W-1:0] PAGE_COUNT = COUNT_W'(PAGE_BYTES);
    localparam logic [COUNT_W-1:0] MAX_COUNT  = COUNT_W'(MAX_REQUEST_BYTES);

    typedef struct packed {
        logic [ADDR_W-1:0]  start_address;
        logic [COUNT_W-1:0] byte_count;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] chunk_address;
        logic [LEN_W-1:0]  chunk_length;
        logic              last_chunk;
    } t_chunk;

    typedef struct packed {
        logic [COUNT_W-1:0] len;
        logic               last;
        logic [ADDR_W-1:0]  next_addr;
        logic [COUNT_W-1:0] next_rem;
    } t_step;

    typedef enum logic {
        ST_IDLE,
        ST_SPLIT
    } t_state;

endpackage

// File: rtl/fwps_step_unit.sv
// ----------------------------------------------------------------------------
// fwps_step_unit
// Shared chunk unit: compares the bytes left against the room in the current
// page and yields one chunk length, its last mark, and the next address and
// remaining count.
// ----------------------------------------------------------------------------
module fwps_step_unit
    import fwps_pkg::*;
(
    input  logic [ADDR_W-1:0]  i_addr,
    input  logic [COUNT_W-1:0] i_rem,
    input  logic               i_strict,
    output t_step              o_step
);

    logic [OFF_W-1:0]   off;
    logic [COUNT_W-1:0] room;
    logic               rem_lt;
    logic               rem_eq;

    always_comb begin
        off    = i_addr[OFF_W-1:0];
        room   = PAGE_COUNT - COUNT_W'(off);
        rem_lt = i_rem < room;
        rem_eq = i_rem == room;

        o_step.len       = rem_lt ? i_rem : room;
        o_step.last      = i_strict ? rem_lt : (rem_lt || rem_eq);
        o_step.next_addr = i_addr + ADDR_W'(o_step.len);
        o_step.next_rem  = i_rem - o_step.len;
    end

endmodule

// File: rtl/flash_write_page_splitter_core.sv
// ----------------------------------------------------------------------------
// flash_write_page_splitter_core
// Splits a flash write request into page-program chunks that never cross a page
// boundary, one chunk per cycle through a shared chunk unit while unstalled.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  request  | in        | i_in_valid, o_in_stall | i_in_data  (t_req)
//  chunk    | out       | o_out_valid, i_out_stall | o_out_data (t_chunk)
//
//  A request is loaded into the sequencer, then split into chunks that leave
//  one per cycle unless the output stalls.
//  o_in_stall is high while a request is being split.
//  A stalled chunk holds in the output register and pauses the split.
//  Reset clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
module flash_write_page_splitter_core
    import fwps_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_stall,
    input  t_req   i_in_data,
    output logic   o_out_valid,
    input  logic   i_out_stall,
    output t_chunk o_out_data
);

    t_state             r_state, n_state;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic [COUNT_W-1:0] r_rem, n_rem;
    logic               r_strict, n_strict;
    t_chunk             r_out, n_out;
    logic               r_out_valid, n_out_valid;

    t_step              step;
    logic               in_xfer;
    logic               advance;

    fwps_step_unit u_step (
        .i_addr   (r_addr),
        .i_rem    (r_rem),
        .i_strict (r_strict),
        .o_step   (step)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign advance     = (r_state == ST_SPLIT) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) n_state = ST_SPLIT;
            end
            ST_SPLIT: begin
                if (advance && step.last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_addr      = r_addr;
        n_rem       = r_rem;
        n_strict    = r_strict;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_addr   = i_in_data.start_address;
                    n_rem    = (i_in_data.byte_count > MAX_COUNT) ? MAX_COUNT
                                                                  : i_in_data.byte_count;
                    n_strict = (i_in_data.start_address[OFF_W-1:0] == '0);
                end
            end
            ST_SPLIT: begin
                if (advance) begin
                    n_out.chunk_address = r_addr;
                    n_out.chunk_length  = LEN_W'(step.len);
                    n_out.last_chunk    = step.last;
                    n_out_valid         = 1'b1;
                    n_addr              = step.next_addr;
                    n_rem               = step.next_rem;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_rem    <= n_rem;
        r_strict <= n_strict;
        r_out    <= n_out;
    end

endmodule
